@@ sv/gas_pkg.sv @@
// Shared types, constants and helper functions for the gravity step core.
package gas_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int WIDE_BITS = 128;

	// Largest magnitude any intermediate value may take.
	localparam logic [61:0] CAP = 62'h2000_0000_0000_0000;

	// Configuration register indexes.
	localparam logic [2:0] REG_GRAV      = 3'd0;
	localparam logic [2:0] REG_DT        = 3'd1;
	localparam logic [2:0] REG_START_PX  = 3'd2;
	localparam logic [2:0] REG_START_PY  = 3'd3;
	localparam logic [2:0] REG_START_VX  = 3'd4;
	localparam logic [2:0] REG_START_VY  = 3'd5;

	// Input op codes.
	localparam logic OP_ATTRACT = 1'b0;
	localparam logic OP_COMMIT  = 1'b1;

	typedef enum logic [1:0] {
		AR_MUL,
		AR_DIV,
		AR_SQRT
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	// Magnitude of a signed word.
	function automatic logic [32:0] mag_word(input logic [31:0] v);
		logic [32:0] e;
		begin
			e = {v[31], v};
			mag_word = v[31] ? (33'd0 - e) : e;
		end
	endfunction

	// Clamp a wide unsigned value to the cap.
	function automatic logic [61:0] cap_wide(input logic [127:0] v);
		begin
			cap_wide = (v > {66'd0, CAP}) ? CAP : v[61:0];
		end
	endfunction

	// Floor of a signed product shifted right by 16 or by 33, capped.
	function automatic logic signed [62:0] mul_shift(input logic [127:0] p,
			input logic neg, input logic big);
		logic [127:0] s;
		logic [61:0]  m;
		begin
			if (big) begin
				s = (p + (neg ? {95'd0, {33{1'b1}}} : 128'd0)) >> (2 * FRAC_BITS + 1);
			end else begin
				s = (p + (neg ? {112'd0, {16{1'b1}}} : 128'd0)) >> FRAC_BITS;
			end
			m = cap_wide(s);
			mul_shift = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		end
	endfunction

	// Saturate a wide signed sum to the signed word range.
	function automatic logic [31:0] sat_word(input logic signed [65:0] v);
		begin
			if (v > 66'sd2147483647) begin
				sat_word = 32'h7fff_ffff;
			end else if (v < -66'sd2147483648) begin
				sat_word = 32'h8000_0000;
			end else begin
				sat_word = v[31:0];
			end
		end
	endfunction

endpackage

@@ sv/gas_arith.sv @@
// Bit-serial arithmetic unit: shift-add multiply, restoring divide, square root.
module gas_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  gas_pkg::arith_req_t req,
	input  logic [127:0]        a,
	input  logic [127:0]        b,
	output logic                done,
	output logic [127:0]        res
);
	import gas_pkg::*;

	logic         busy_q;
	logic         done_q;
	arith_op_t    op_q;
	logic [7:0]   cnt_q;
	logic [127:0] acc_q;
	logic [127:0] sh_q;
	logic [127:0] b_q;
	logic [63:0]  mp_q;

	logic [127:0] div_r;
	logic         div_ge;
	logic [127:0] sq_r;
	logic [127:0] sq_t;
	logic         sq_ge;

	// One step of each iteration.
	always_comb begin
		div_r  = {acc_q[126:0], sh_q[127]};
		div_ge = div_r >= b_q;
		sq_r   = {acc_q[125:0], sh_q[127:126]};
		sq_t   = {62'd0, mp_q, 2'b01};
		sq_ge  = sq_r >= sq_t;
	end

	// Control: count the digits of the running operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 8'd0;
			op_q   <= AR_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == AR_DIV) ? 8'd128 : 8'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one bit (or one bit pair for the root) per cycle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= 128'd0;
			sh_q  <= a;
			b_q   <= b;
			mp_q  <= (req.op == AR_MUL) ? b[63:0] : 64'd0;
		end else if (busy_q) begin
			unique case (op_q)
				AR_MUL: begin
					if (mp_q[0]) acc_q <= acc_q + sh_q;
					sh_q <= sh_q << 1;
					mp_q <= mp_q >> 1;
				end
				AR_DIV: begin
					acc_q <= div_ge ? (div_r - b_q) : div_r;
					sh_q  <= {sh_q[126:0], div_ge};
				end
				AR_SQRT: begin
					acc_q <= sq_ge ? (sq_r - sq_t) : sq_r;
					sh_q  <= sh_q << 2;
					mp_q  <= {mp_q[62:0], sq_ge};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done = done_q;

	always_comb begin
		unique case (op_q)
			AR_MUL:  res = acc_q;
			AR_DIV:  res = sh_q;
			AR_SQRT: res = {64'd0, mp_q};
			default: res = acc_q;
		endcase
	end

endmodule

@@ sv/gravity_attraction_step_core.sv @@
// Top level of the gravity step core: sequencer, body state and channels.
//
// Input channel (in_valid/in_ready) takes one beat per item: op selects an
// attract item (other body position and mass) or a commit item. Each item
// gives exactly one result beat on the output channel (out_valid/out_ready).
// Configuration is a plain write port (cfg_we, cfg_idx, cfg_data) used while
// the core is idle; a write to a start register also loads that component
// of the previous and new state.
// One item at a time: an attract item runs 12 multiplies, 3 divides and one
// square root on the shared bit-serial unit. Coincident bodies skip to the
// integration. A commit item copies the new state into the previous state,
// clears the acceleration and goes straight to the output register.
// Reset clears the acceleration, loads zero position and velocity and the
// default constant and time step. A stalled receiver holds the result in the
// output register; the next item may be accepted and worked on meanwhile,
// and waits at its end until the output register is free.
module gravity_attraction_step_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [31:0] other_pos_x,
	input  logic [31:0] other_pos_y,
	input  logic [31:0] other_mass,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] pos_x_out,
	output logic [31:0] pos_y_out,
	output logic [31:0] vel_x_out,
	output logic [31:0] vel_y_out,
	output logic        zero_distance,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	import gas_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MXX, ST_MYY, ST_SQRT, ST_GM, ST_F, ST_CX, ST_QX, ST_CY,
		ST_QY, ST_DT2, ST_AVX, ST_VPX, ST_APX, ST_AVY, ST_VPY, ST_APY, ST_OUT
	} state_t;

	state_t       state_q;
	logic         issued_q;
	logic [31:0]  grav_q, dt_q;
	logic [31:0]  ppx_q, ppy_q, pvx_q, pvy_q;
	logic [31:0]  npx_q, npy_q, nvx_q, nvy_q;
	logic [31:0]  ax_q, ay_q;
	logic [31:0]  mass_q;
	logic [32:0]  mx_q, my_q;
	logic         sx_q, sy_q;
	logic         flag_q;
	logic [127:0] t_q;
	logic [66:0]  d2_q;
	logic [33:0]  d_q;
	logic [61:0]  f_q;
	logic [63:0]  dt2_q;
	logic signed [62:0] tv_q;

	arith_req_t   ar_req;
	logic [127:0] ar_a, ar_b, ar_res;
	logic         ar_done;

	logic signed [33:0] dx_c, dy_c;
	logic [66:0]        d2_c;
	logic [61:0]        cq_c;
	logic signed [62:0] ms_c;
	logic               ms_neg, ms_big;

	gas_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.a      (ar_a),
		.b      (ar_b),
		.done   (ar_done),
		.res    (ar_res)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign dx_c = $signed({{2{other_pos_x[31]}}, other_pos_x}) - $signed({{2{ppx_q[31]}}, ppx_q});
	assign dy_c = $signed({{2{other_pos_y[31]}}, other_pos_y}) - $signed({{2{ppy_q[31]}}, ppy_q});
	assign d2_c = t_q[66:0] + ar_res[66:0];
	assign cq_c = cap_wide(ar_res);

	// Operands for the serial unit, per step.
	always_comb begin
		ar_a   = 128'd0;
		ar_b   = 128'd0;
		ar_req.op = AR_MUL;
		ms_neg = 1'b0;
		ms_big = 1'b0;
		unique case (state_q)
			ST_MXX: begin ar_a = {95'd0, mx_q}; ar_b = {95'd0, mx_q}; end
			ST_MYY: begin ar_a = {95'd0, my_q}; ar_b = {95'd0, my_q}; end
			ST_SQRT: begin ar_a = {61'd0, d2_q}; ar_req.op = AR_SQRT; end
			ST_GM: begin ar_a = {96'd0, grav_q}; ar_b = {96'd0, mass_q}; end
			ST_F: begin ar_a = t_q; ar_b = {61'd0, d2_q}; ar_req.op = AR_DIV; end
			ST_CX: begin ar_a = {66'd0, f_q}; ar_b = {95'd0, mx_q}; end
			ST_QX: begin ar_a = t_q; ar_b = {94'd0, d_q}; ar_req.op = AR_DIV; end
			ST_CY: begin ar_a = {66'd0, f_q}; ar_b = {95'd0, my_q}; end
			ST_QY: begin ar_a = t_q; ar_b = {94'd0, d_q}; ar_req.op = AR_DIV; end
			ST_DT2: begin ar_a = {96'd0, dt_q}; ar_b = {96'd0, dt_q}; end
			ST_AVX: begin
				ar_a = {95'd0, mag_word(ax_q)}; ar_b = {96'd0, dt_q}; ms_neg = ax_q[31];
			end
			ST_VPX: begin
				ar_a = {95'd0, mag_word(pvx_q)}; ar_b = {96'd0, dt_q}; ms_neg = pvx_q[31];
			end
			ST_APX: begin
				ar_a = {95'd0, mag_word(ax_q)}; ar_b = {64'd0, dt2_q};
				ms_neg = ax_q[31]; ms_big = 1'b1;
			end
			ST_AVY: begin
				ar_a = {95'd0, mag_word(ay_q)}; ar_b = {96'd0, dt_q}; ms_neg = ay_q[31];
			end
			ST_VPY: begin
				ar_a = {95'd0, mag_word(pvy_q)}; ar_b = {96'd0, dt_q}; ms_neg = pvy_q[31];
			end
			ST_APY: begin
				ar_a = {95'd0, mag_word(ay_q)}; ar_b = {64'd0, dt2_q};
				ms_neg = ay_q[31]; ms_big = 1'b1;
			end
			default: begin
				ar_a = 128'd0;
			end
		endcase
		ar_req.start = (state_q != ST_IDLE) && (state_q != ST_OUT) && !issued_q;
		ms_c = mul_shift(ar_res, ms_neg, ms_big);
	end

	// Sequencer, body state, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issued_q  <= 1'b0;
			grav_q    <= 32'd65536;
			dt_q      <= 32'd6554;
			ppx_q     <= 32'd0;
			ppy_q     <= 32'd0;
			pvx_q     <= 32'd0;
			pvy_q     <= 32'd0;
			npx_q     <= 32'd0;
			npy_q     <= 32'd0;
			nvx_q     <= 32'd0;
			nvy_q     <= 32'd0;
			ax_q      <= 32'd0;
			ay_q      <= 32'd0;
			flag_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// The output register loads a new beat or empties when its beat is taken.
			if ((state_q == ST_OUT) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (ar_req.start) issued_q <= 1'b1;

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_GRAV:     grav_q <= cfg_data;
					REG_DT:       dt_q <= cfg_data;
					REG_START_PX: begin ppx_q <= cfg_data; npx_q <= cfg_data; end
					REG_START_PY: begin ppy_q <= cfg_data; npy_q <= cfg_data; end
					REG_START_VX: begin pvx_q <= cfg_data; nvx_q <= cfg_data; end
					REG_START_VY: begin pvy_q <= cfg_data; nvy_q <= cfg_data; end
					default: begin
						grav_q <= grav_q;
					end
				endcase
			end

			if (state_q == ST_IDLE) begin
				if (in_valid) begin
					flag_q <= 1'b0;
					if (op == OP_COMMIT) begin
						ppx_q   <= npx_q;
						ppy_q   <= npy_q;
						pvx_q   <= nvx_q;
						pvy_q   <= nvy_q;
						ax_q    <= 32'd0;
						ay_q    <= 32'd0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_MXX;
					end
				end
			end else if (state_q == ST_OUT) begin
				if (!out_valid || out_ready) begin
					state_q   <= ST_IDLE;
				end
			end else if (ar_done) begin
				issued_q <= 1'b0;
				unique case (state_q)
					ST_MXX: begin t_q <= ar_res; state_q <= ST_MYY; end
					ST_MYY: begin
						if (d2_c == 67'd0) begin
							flag_q  <= 1'b1;
							state_q <= ST_DT2;
						end else begin
							state_q <= ST_SQRT;
						end
					end
					ST_SQRT: begin d_q <= ar_res[33:0]; state_q <= ST_GM; end
					ST_GM: begin t_q <= ar_res << FRAC_BITS; state_q <= ST_F; end
					ST_F: begin f_q <= cq_c; state_q <= ST_CX; end
					ST_CX: begin t_q <= ar_res; state_q <= ST_QX; end
					ST_QX: begin
						ax_q <= sat_word($signed({{34{ax_q[31]}}, ax_q})
							+ (sx_q ? -$signed({4'd0, cq_c}) : $signed({4'd0, cq_c})));
						state_q <= ST_CY;
					end
					ST_CY: begin t_q <= ar_res; state_q <= ST_QY; end
					ST_QY: begin
						ay_q <= sat_word($signed({{34{ay_q[31]}}, ay_q})
							+ (sy_q ? -$signed({4'd0, cq_c}) : $signed({4'd0, cq_c})));
						state_q <= ST_DT2;
					end
					ST_DT2: begin dt2_q <= ar_res[63:0]; state_q <= ST_AVX; end
					ST_AVX: begin
						nvx_q <= sat_word($signed({{34{pvx_q[31]}}, pvx_q})
							+ $signed({{3{ms_c[62]}}, ms_c}));
						state_q <= ST_VPX;
					end
					ST_VPX: begin tv_q <= ms_c; state_q <= ST_APX; end
					ST_APX: begin
						npx_q <= sat_word($signed({{34{ppx_q[31]}}, ppx_q})
							+ $signed({{3{tv_q[62]}}, tv_q}) + $signed({{3{ms_c[62]}}, ms_c}));
						state_q <= ST_AVY;
					end
					ST_AVY: begin
						nvy_q <= sat_word($signed({{34{pvy_q[31]}}, pvy_q})
							+ $signed({{3{ms_c[62]}}, ms_c}));
						state_q <= ST_VPY;
					end
					ST_VPY: begin tv_q <= ms_c; state_q <= ST_APY; end
					ST_APY: begin
						npy_q <= sat_word($signed({{34{ppy_q[31]}}, ppy_q})
							+ $signed({{3{tv_q[62]}}, tv_q}) + $signed({{3{ms_c[62]}}, ms_c}));
						state_q <= ST_OUT;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Item operands and result beat payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			mx_q   <= (dx_c[33] ? 33'(-dx_c) : 33'(dx_c));
			my_q   <= (dy_c[33] ? 33'(-dy_c) : 33'(dy_c));
			sx_q   <= dx_c[33];
			sy_q   <= dy_c[33];
			mass_q <= other_mass;
		end
		if ((state_q == ST_MYY) && ar_done) d2_q <= d2_c;
		if ((state_q == ST_OUT) && (!out_valid || out_ready)) begin
			pos_x_out     <= npx_q;
			pos_y_out     <= npy_q;
			vel_x_out     <= nvx_q;
			vel_y_out     <= nvy_q;
			zero_distance <= flag_q;
		end
	end

endmodule
